// File: rtl/hct_pkg.sv
// Shared types, constants and a helper function for the console timer.
package hct_pkg;

  // Request and response payloads.
  typedef struct packed {
    logic        at_cd_phase;
    logic        at_fg_phase;
    logic        bus_read;
    logic        bus_write;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic       read_valid;
    logic [7:0] read_data;
    logic       timer_irq;
  } rsp_t;

  // Architectural timer state.
  typedef struct packed {
    logic [15:0] divider;
    logic [7:0]  counter;
    logic [7:0]  reload_value;
    logic [2:0]  control;
    logic        tick_level;
    logic        top_bit_sync;
    logic        irq_level;
  } state_t;

  // Address decode result.
  typedef struct packed {
    logic       hit;
    logic [1:0] off;
  } dec_t;

  localparam logic [1:0] OFF_DIV  = 2'd0;
  localparam logic [1:0] OFF_CNT  = 2'd1;
  localparam logic [1:0] OFF_RLD  = 2'd2;
  localparam logic [1:0] OFF_CTRL = 2'd3;

  localparam logic [15:0] DIV_RESET   = 16'hEAF2;
  localparam logic [7:0]  CTRL_RD_SET = 8'b1111_1000;
  localparam int          CTRL_RUN    = 2;

  // Divider bit watched for each rate select code.
  localparam logic [15:0] RATE_MASK [4] = '{16'h0080, 16'h0002, 16'h0008, 16'h0020};

  // Gated tick source for the falling-edge detector.
  function automatic logic tick_source(input logic [15:0] div, input logic [2:0] ctrl);
    tick_source = (|(div & RATE_MASK[ctrl[1:0]])) & ctrl[CTRL_RUN];
  endfunction

endpackage

// File: rtl/hct_decode.sv
// Address decode and register read mux for the console timer.
module hct_decode import hct_pkg::*; #(
  parameter logic [15:0] REGISTER_BASE = 16'hFF04
) (
  input  req_t       req,
  input  state_t     st,
  output dec_t       dec,
  output logic       read_valid,
  output logic [7:0] read_data
);

  logic [15:0] off_full;

  assign off_full = req.bus_address - REGISTER_BASE;
  assign dec.hit  = (req.bus_address >= REGISTER_BASE) && (off_full < 16'd4);
  assign dec.off  = off_full[1:0];

  // Reads see the state as it stood before this phase.
  always_comb begin
    read_valid = req.bus_read && dec.hit;
    read_data  = 8'h00;
    if (read_valid) begin
      case (dec.off)
        OFF_DIV:  read_data = st.divider[13:6];
        OFF_CNT:  read_data = st.counter;
        OFF_RLD:  read_data = st.reload_value;
        OFF_CTRL: read_data = CTRL_RD_SET | {5'b00000, st.control};
        default:  read_data = 8'h00;
      endcase
    end
  end

endmodule

// File: rtl/hct_core.sv
// Timer state registers and the per-phase next-state logic.
module hct_core import hct_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   update,
  input  req_t   req,
  input  dec_t   dec,
  output state_t st,
  output state_t st_next
);

  // Falling edge on the tick source steps the counter; a pending irq reloads it.
  function automatic state_t step_counter(input state_t s);
    state_t r;
    logic   lvl;
    r   = s;
    lvl = tick_source(s.divider, s.control);
    if (s.tick_level && !lvl) begin
      r.counter = s.counter + 8'd1;
    end
    r.tick_level = lvl;
    if (s.irq_level) begin
      r.counter      = s.reload_value;
      r.top_bit_sync = 1'b0;
    end
    step_counter = r;
  endfunction

  always_comb begin
    st_next = st;
    if (req.at_cd_phase) begin
      st_next.divider      = st.divider + 16'd1;
      st_next.irq_level    = st.top_bit_sync && !st.counter[7];
      st_next.top_bit_sync = st.counter[7];
      st_next              = step_counter(st_next);
    end
    if (req.at_fg_phase && req.bus_write) begin
      if (dec.hit) begin
        case (dec.off)
          OFF_DIV:  st_next.divider = 16'h0000;
          OFF_CNT: begin
            st_next.counter      = req.write_data;
            st_next.top_bit_sync = 1'b0;
          end
          OFF_RLD:  st_next.reload_value = req.write_data;
          OFF_CTRL: st_next.control = req.write_data[2:0];
          default:  st_next.control = st.control;
        endcase
      end
      st_next = step_counter(st_next);
    end
    if (st_next.irq_level) begin
      st_next.top_bit_sync = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.divider      <= DIV_RESET;
      st.counter      <= 8'h00;
      st.reload_value <= 8'h00;
      st.control      <= 3'b000;
      st.tick_level   <= 1'b0;
      st.top_bit_sync <= 1'b0;
      st.irq_level    <= 1'b0;
    end else if (update) begin
      st <= st_next;
    end
  end

endmodule

// File: rtl/handheld_console_timer.sv
// Top level of the console timer: request register, timer core, response register.
//
// Usage:
//   Each request on req is one clock phase: two phase-slot flags, an optional
//   bus read and/or write, an address and write data. Every request yields
//   exactly one response on rsp: the read hit flag, the read byte (zero on a
//   miss) and the interrupt level after that phase.
//   Both channels use valid/ready; a request moves on a clock edge where valid
//   and ready are both high.
//   A request goes through the request register and the response register.
//   Throughput: one request per cycle while rsp is not held. The request
//   register feeds one pass of short next-state logic straight into the
//   response register and the timer state, so nothing loops across cycles.
//   Stall: when rsp is held, the response register keeps its value, the
//   pending request waits in the request register, and req_ready drops only
//   once both are full. Timer state advances only when a request moves into
//   the response register.
//   Reset (rst, synchronous, active high): divider to 0xEAF2, all other timer
//   state to zero, both pipeline registers empty.
module handheld_console_timer import hct_pkg::*; #(
  parameter logic [15:0] REGISTER_BASE = 16'hFF04
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  // Request register.
  logic   pipe_valid;
  req_t   pipe_req;
  logic   advance;

  // Timer state and decode.
  state_t     st;
  state_t     st_next;
  dec_t       dec;
  logic       rd_valid;
  logic [7:0] rd_data;

  // Move a held request forward whenever the response slot is free or draining.
  assign advance   = pipe_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !pipe_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (req_ready) begin
      pipe_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      pipe_req <= req;
    end
  end

  hct_decode #(
    .REGISTER_BASE(REGISTER_BASE)
  ) u_decode (
    .req        (pipe_req),
    .st         (st),
    .dec        (dec),
    .read_valid (rd_valid),
    .read_data  (rd_data)
  );

  hct_core u_core (
    .clk     (clk),
    .rst     (rst),
    .update  (advance),
    .req     (pipe_req),
    .dec     (dec),
    .st      (st),
    .st_next (st_next)
  );

  // Response register: drop valid once taken, load a new response on advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.read_valid <= rd_valid;
      rsp.read_data  <= rd_data;
      rsp.timer_irq  <= st_next.irq_level;
    end
  end

  // The sync bit is always cleared while the interrupt is high.
  a_irq_clears_sync: assert property (@(posedge clk) disable iff (rst)
    st.irq_level |-> !st.top_bit_sync)
    else $error("top_bit_sync set while irq_level high");

  // A stalled request register holds its request.
  a_pipe_hold: assert property (@(posedge clk) disable iff (rst)
    (pipe_valid && !advance) |=> (pipe_valid && $stable(pipe_req)))
    else $error("held request lost or changed");

  // Input backpressure only comes from a full, stalled response register.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (pipe_valid && rsp_valid && !rsp_ready))
    else $error("req_ready low without downstream stall");

  // Timer state only changes when a request moves into the response register.
  a_state_update: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("timer state changed without a request");

endmodule
